@@ hw/rtl/ray_window_border_hit_unit_macros.svh @@
// assertion macros for the ray window border hit unit
// expects clk and rst_n in the scope of use
`ifndef RAY_WINDOW_BORDER_HIT_UNIT_MACROS_SVH
`define RAY_WINDOW_BORDER_HIT_UNIT_MACROS_SVH

// checked only out of reset
`define RWBH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked at every edge, reset included
`define RWBH_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/rwbh_pkg.sv @@
// shared types, constants and the cordic angle table of the ray border hit unit
// no dependencies
`default_nettype none

package rwbh_pkg;

  localparam int CORDIC_STEPS = 18;
  localparam int DIV_STEPS    = 22;

  localparam logic signed [31:0] CORDIC_START = 32'sd652032874;

  // hit codes
  localparam logic [3:0] KIND_NONE   = 4'd0;
  localparam logic [3:0] KIND_TOP    = 4'd1;
  localparam logic [3:0] KIND_BOTTOM = 4'd2;
  localparam logic [3:0] KIND_LEFT   = 4'd3;
  localparam logic [3:0] KIND_RIGHT  = 4'd4;
  localparam logic [3:0] KIND_TL     = 4'd5;
  localparam logic [3:0] KIND_TR     = 4'd6;
  localparam logic [3:0] KIND_BL     = 4'd7;
  localparam logic [3:0] KIND_BR     = 4'd8;

  // register indexes
  localparam logic [1:0] CFG_WIDTH_IDX  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT_IDX = 2'd1;
  localparam logic [1:0] CFG_MARGIN_IDX = 2'd2;

  // query context carried along the rotation cells
  typedef struct packed {
    logic [21:0] x0;
    logic [21:0] y0;
    logic [21:0] xr;
    logic [21:0] yt;
    logic [15:0] head;
    logic [23:0] travel;
    logic [9:0]  margin;
  } ray_ctx_t;

  // result under construction carried along the divider cells
  typedef struct packed {
    logic [21:0] ex;
    logic [21:0] ey;
    logic        mv_x;
    logic        mv_y;
    logic [21:0] base;
    logic        fwd;
    logic [21:0] lim;
    logic [3:0]  kind;
  } fin_ctx_t;

  // angle of each rotation step, 2^32 per turn
  function automatic logic signed [31:0] atan_turn(input logic [4:0] i);
    logic signed [31:0] r;
    case (i)
      5'd0:    r = 32'sd536870912;
      5'd1:    r = 32'sd316933406;
      5'd2:    r = 32'sd167458907;
      5'd3:    r = 32'sd85004756;
      5'd4:    r = 32'sd42667331;
      5'd5:    r = 32'sd21354465;
      5'd6:    r = 32'sd10679838;
      5'd7:    r = 32'sd5340245;
      5'd8:    r = 32'sd2670163;
      5'd9:    r = 32'sd1335087;
      5'd10:   r = 32'sd667544;
      5'd11:   r = 32'sd333772;
      5'd12:   r = 32'sd166886;
      5'd13:   r = 32'sd83443;
      5'd14:   r = 32'sd41722;
      5'd15:   r = 32'sd20861;
      5'd16:   r = 32'sd10430;
      5'd17:   r = 32'sd5215;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // step a coordinate forwards (clamped to lim) or backwards (clamped to 0)
  function automatic logic [21:0] move_pt(input logic [21:0] p, input logic [25:0] q,
                                          input logic fwd, input logic [21:0] lim);
    logic [26:0] sum;
    logic [21:0] r;
    sum = 27'(p) + 27'(q);
    if (fwd) begin
      r = (sum > 27'(lim)) ? lim : sum[21:0];
    end else begin
      r = (q > 26'(p)) ? 22'd0 : p - q[21:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rwbh_cordic_cell.sv @@
// one rotation step of the direction cordic, registered
// depends on rwbh_pkg
`default_nettype none

module rwbh_cordic_cell import rwbh_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [4:0]         step,
  input  wire logic               prev_vld,
  input  wire logic signed [31:0] prev_x,
  input  wire logic signed [31:0] prev_y,
  input  wire logic signed [31:0] prev_z,
  input  wire ray_ctx_t           prev_ctx,
  output logic                    next_vld,
  output logic signed [31:0]      next_x,
  output logic signed [31:0]      next_y,
  output logic signed [31:0]      next_z,
  output ray_ctx_t                next_ctx
);

  logic               vld_r;
  logic signed [31:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt, xs, ys, ang;
  ray_ctx_t           ctx_r;

  // arithmetic shift floors towards minus infinity
  always_comb begin
    xs  = prev_x >>> step;
    ys  = prev_y >>> step;
    ang = atan_turn(step);
    if (prev_z >= 0) begin
      x_nxt = prev_x - ys;
      y_nxt = prev_y + xs;
      z_nxt = prev_z - ang;
    end else begin
      x_nxt = prev_x + ys;
      y_nxt = prev_y - xs;
      z_nxt = prev_z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= prev_vld;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    ctx_r <= prev_ctx;
  end

  assign next_vld = vld_r;
  assign next_x   = x_r;
  assign next_y   = y_r;
  assign next_z   = z_r;
  assign next_ctx = ctx_r;

endmodule

`default_nettype wire

@@ hw/rtl/rwbh_div_cell.sv @@
// one restoring division step, one quotient bit, registered
// depends on rwbh_pkg
`default_nettype none

module rwbh_div_cell import rwbh_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        prev_vld,
  input  wire logic [38:0] prev_rem,
  input  wire logic [36:0] prev_den,
  input  wire logic [21:0] prev_quo,
  input  wire fin_ctx_t    prev_fin,
  output logic             next_vld,
  output logic [38:0]      next_rem,
  output logic [36:0]      next_den,
  output logic [21:0]      next_quo,
  output fin_ctx_t         next_fin
);

  logic        vld_r, ge;
  logic [38:0] rem_r, rem_nxt;
  logic [36:0] den_r;
  logic [21:0] quo_r;
  fin_ctx_t    fin_r;

  // divisor arrives pre-shifted, next cell sees it one place lower
  always_comb begin
    ge      = prev_rem >= 39'(prev_den);
    rem_nxt = ge ? prev_rem - 39'(prev_den) : prev_rem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= prev_vld;
    end
    rem_r <= rem_nxt;
    den_r <= prev_den >> 1;
    quo_r <= {prev_quo[20:0], ge};
    fin_r <= prev_fin;
  end

  assign next_vld = vld_r;
  assign next_rem = rem_r;
  assign next_den = den_r;
  assign next_quo = quo_r;
  assign next_fin = fin_r;

endmodule

`default_nettype wire

@@ hw/rtl/ray_window_border_hit_unit.sv @@
// top level of the ray window border hit unit
// depends on rwbh_pkg, rwbh_cordic_cell, rwbh_div_cell and the assertion macro header
`default_nettype none
`include "ray_window_border_hit_unit_macros.svh"

// usage
//  a query (start point, heading, travel distance) transfers at a rising edge
//  with start high and busy low. busy is high only from reset until the edge
//  that samples rst_n high, so a new query may follow in every cycle
//  the result (end point and hit code) is loaded onto the out_ ports with
//  out_valid high from the output register and transfers in query order;
//  the receiver cannot stall, so nothing is held back
//  the chain holds an input register, 18 cordic cells, three arithmetic
//  stages, 22 restoring divider cells and the output register
//  throughput is one query per cycle, each cell holding one query
//  window size and axis margin are written through cfg_we/cfg_index/cfg_wdata
//  between queries; they are sampled when a query transfers
//  synchronous reset empties the pipeline (no result strobes come out of it)
//  and restores the window to 1920 by 1080 with a margin of 1

module ray_window_border_hit_unit import rwbh_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [21:0] in_start_x,
  input  wire logic [21:0] in_start_y,
  input  wire logic [15:0] in_heading,
  input  wire logic [23:0] in_travel_distance,
  output logic             out_valid,
  output logic [21:0]      out_end_x,
  output logic [21:0]      out_end_y,
  output logic [3:0]       out_hit_kind,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_wdata
);

  // configuration registers
  logic [14:0] width_r, height_r;
  logic [9:0]  margin_r;
  logic        busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 15'd1920;
      height_r <= 15'd1080;
      margin_r <= 10'd1;
      busy_r   <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH_IDX:  width_r  <= cfg_wdata;
          CFG_HEIGHT_IDX: height_r <= cfg_wdata;
          CFG_MARGIN_IDX: margin_r <= cfg_wdata[9:0];
          default: ;
        endcase
      end
    end
  end

  assign busy = busy_r;

  // input stage: clamp window size, right and top edges, clamp start point
  logic [14:0] wc, hc, wm1, hm1;
  logic [21:0] xr_c, yt_c;
  logic        s0_vld_r;
  ray_ctx_t    s0_ctx_r, s0_ctx_nxt;

  always_comb begin
    wc   = (width_r == 15'd0) ? 15'd1 : (width_r > 15'd16384) ? 15'd16384 : width_r;
    hc   = (height_r == 15'd0) ? 15'd1 : (height_r > 15'd16384) ? 15'd16384 : height_r;
    wm1  = wc - 15'd1;
    hm1  = hc - 15'd1;
    xr_c = {wm1[13:0], 8'd0};
    yt_c = {hm1[13:0], 8'd0};
    s0_ctx_nxt.xr     = xr_c;
    s0_ctx_nxt.yt     = yt_c;
    s0_ctx_nxt.x0     = (in_start_x > xr_c) ? xr_c : in_start_x;
    s0_ctx_nxt.y0     = (in_start_y > yt_c) ? yt_c : in_start_y;
    s0_ctx_nxt.head   = in_heading;
    s0_ctx_nxt.travel = in_travel_distance;
    s0_ctx_nxt.margin = margin_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start && !busy_r;
    end
    s0_ctx_r <= s0_ctx_nxt;
  end

  // cordic chain, rotating through the low 30 bits of the turn angle
  logic               c_vld [0:CORDIC_STEPS];
  logic signed [31:0] c_x   [0:CORDIC_STEPS];
  logic signed [31:0] c_y   [0:CORDIC_STEPS];
  logic signed [31:0] c_z   [0:CORDIC_STEPS];
  ray_ctx_t           c_ctx [0:CORDIC_STEPS];

  assign c_vld[0] = s0_vld_r;
  assign c_x[0]   = CORDIC_START;
  assign c_y[0]   = 32'sd0;
  assign c_z[0]   = {2'b00, s0_ctx_r.head[13:0], 16'd0};
  assign c_ctx[0] = s0_ctx_r;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    rwbh_cordic_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .step     (5'(g)),
      .prev_vld (c_vld[g]),
      .prev_x   (c_x[g]),
      .prev_y   (c_y[g]),
      .prev_z   (c_z[g]),
      .prev_ctx (c_ctx[g]),
      .next_vld (c_vld[g+1]),
      .next_x   (c_x[g+1]),
      .next_y   (c_y[g+1]),
      .next_z   (c_z[g+1]),
      .next_ctx (c_ctx[g+1])
    );
  end

  // rounding to q15 magnitude plus sign, zero counts as positive
  function automatic logic [16:0] to_q15(input logic signed [31:0] v);
    logic [31:0] m;
    logic [16:0] r;
    logic [15:0] mag;
    m   = (v < 0) ? 32'(-v) : 32'(v);
    r   = 17'((33'(m) + 33'd16384) >> 15);
    mag = (r > 17'd32768) ? 16'd32768 : r[15:0];
    return {(v < 0) && (mag != 16'd0), mag};
  endfunction

  // quadrant stage
  logic signed [31:0] qc, qs;
  logic [16:0]        qc15, qs15;
  logic               q_vld_r;
  logic [15:0]        q_cm_r, q_sm_r;
  logic               q_right_r, q_up_r;
  ray_ctx_t           q_ctx_r;
  ray_ctx_t           cl;

  always_comb begin
    cl = c_ctx[CORDIC_STEPS];
    case (cl.head[15:14])
      2'd0:    begin qc = c_x[CORDIC_STEPS];  qs = c_y[CORDIC_STEPS];  end
      2'd1:    begin qc = -c_y[CORDIC_STEPS]; qs = c_x[CORDIC_STEPS];  end
      2'd2:    begin qc = -c_x[CORDIC_STEPS]; qs = -c_y[CORDIC_STEPS]; end
      default: begin qc = c_y[CORDIC_STEPS];  qs = -c_x[CORDIC_STEPS]; end
    endcase
    qc15 = to_q15(qc);
    qs15 = to_q15(qs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r <= 1'b0;
    end else begin
      q_vld_r <= c_vld[CORDIC_STEPS];
    end
    q_cm_r    <= qc15[15:0];
    q_sm_r    <= qs15[15:0];
    q_right_r <= !qc15[16];
    q_up_r    <= !qs15[16];
    q_ctx_r   <= cl;
  end

  // product stage: cross products and distance projections
  logic [21:0] dx_c, dy_c;
  logic        m_vld_r, m_right_r, m_up_r;
  logic [15:0] m_cm_r, m_sm_r;
  logic [21:0] m_dx_r, m_dy_r;
  logic [37:0] m_lh_r, m_rh_r;
  logic [39:0] m_pc_r, m_ps_r;
  ray_ctx_t    m_ctx_r;

  always_comb begin
    dx_c = q_right_r ? q_ctx_r.xr - q_ctx_r.x0 : q_ctx_r.x0;
    dy_c = q_up_r ? q_ctx_r.yt - q_ctx_r.y0 : q_ctx_r.y0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= q_vld_r;
    end
    m_right_r <= q_right_r;
    m_up_r    <= q_up_r;
    m_cm_r    <= q_cm_r;
    m_sm_r    <= q_sm_r;
    m_dx_r    <= dx_c;
    m_dy_r    <= dy_c;
    m_lh_r    <= 38'(dy_c) * 38'(q_cm_r);
    m_rh_r    <= 38'(dx_c) * 38'(q_sm_r);
    m_pc_r    <= 40'(q_ctx_r.travel) * 40'(q_cm_r);
    m_ps_r    <= 40'(q_ctx_r.travel) * 40'(q_sm_r);
    m_ctx_r   <= q_ctx_r;
  end

  // classify stage: edge, corner, reach test, divider operands
  logic        lt, gt, use_x, reached;
  logic [14:0] hh, vv;
  logic [15:0] dh, dv, hh_c, vv_c;
  logic [15:0] head_v;
  logic [3:0]  kind_hit, kind_side, kind_tb, kind_corner;
  logic [21:0] edge_x, edge_y, alt_x, alt_y;
  logic [25:0] qx, qy;
  logic [38:0] div_num;
  logic [15:0] div_den;
  fin_ctx_t    fin_nxt;
  logic        k_vld_r;
  logic [38:0] k_num_r;
  logic [36:0] k_den_r;
  fin_ctx_t    k_fin_r;

  always_comb begin
    lt = m_lh_r < m_rh_r;
    gt = m_lh_r > m_rh_r;
    kind_side = m_right_r ? KIND_RIGHT : KIND_LEFT;
    kind_tb   = m_up_r ? KIND_TOP : KIND_BOTTOM;
    kind_corner = m_up_r ? (m_right_r ? KIND_TR : KIND_TL)
                         : (m_right_r ? KIND_BR : KIND_BL);
    // angular distance from the horizontal and from the vertical
    head_v = m_ctx_r.head + 16'd16384;
    hh   = m_ctx_r.head[14:0];
    vv   = head_v[14:0];
    hh_c = 16'd32768 - 16'(hh);
    vv_c = 16'd32768 - 16'(vv);
    dh   = (16'(hh) < hh_c) ? 16'(hh) : hh_c;
    dv   = (16'(vv) < vv_c) ? 16'(vv) : vv_c;
    if (lt) begin
      kind_hit = kind_tb;
      use_x    = 1'b0;
    end else if (gt) begin
      kind_hit = kind_side;
      use_x    = 1'b1;
    end else begin
      if (dh <= 16'(m_ctx_r.margin)) begin
        kind_hit = kind_side;
      end else if (dv <= 16'(m_ctx_r.margin)) begin
        kind_hit = kind_tb;
      end else begin
        kind_hit = kind_corner;
      end
      use_x = m_cm_r >= m_sm_r;
    end
    reached = use_x ? (40'({m_dx_r, 15'd0}) <= m_pc_r)
                    : (40'({m_dy_r, 15'd0}) <= m_ps_r);
    edge_x = m_right_r ? m_ctx_r.xr : 22'd0;
    edge_y = m_up_r ? m_ctx_r.yt : 22'd0;
    // point reached when the border is out of range
    qx    = 26'((41'(m_pc_r) + 41'd16384) >> 15);
    qy    = 26'((41'(m_ps_r) + 41'd16384) >> 15);
    alt_x = move_pt(m_ctx_r.x0, qx, m_right_r, m_ctx_r.xr);
    alt_y = move_pt(m_ctx_r.y0, qy, m_up_r, m_ctx_r.yt);
    if (lt) begin
      div_num = 39'(m_lh_r) + 39'(m_sm_r[15:1]);
      div_den = m_sm_r;
    end else begin
      div_num = 39'(m_rh_r) + 39'(m_cm_r[15:1]);
      div_den = m_cm_r;
    end
    fin_nxt.base = lt ? m_ctx_r.x0 : m_ctx_r.y0;
    fin_nxt.fwd  = lt ? m_right_r : m_up_r;
    fin_nxt.lim  = lt ? m_ctx_r.xr : m_ctx_r.yt;
    if (reached) begin
      fin_nxt.ex   = edge_x;
      fin_nxt.ey   = edge_y;
      fin_nxt.mv_x = lt;
      fin_nxt.mv_y = gt;
      fin_nxt.kind = kind_hit;
    end else begin
      fin_nxt.ex   = alt_x;
      fin_nxt.ey   = alt_y;
      fin_nxt.mv_x = 1'b0;
      fin_nxt.mv_y = 1'b0;
      fin_nxt.kind = KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_vld_r <= 1'b0;
    end else begin
      k_vld_r <= m_vld_r;
    end
    k_num_r <= div_num;
    k_den_r <= {div_den, 21'd0};
    k_fin_r <= fin_nxt;
  end

  // divider chain, quotient fits 22 bits since it never exceeds the edge distance
  logic        d_vld [0:DIV_STEPS];
  logic [38:0] d_rem [0:DIV_STEPS];
  logic [36:0] d_den [0:DIV_STEPS];
  logic [21:0] d_quo [0:DIV_STEPS];
  fin_ctx_t    d_fin [0:DIV_STEPS];

  assign d_vld[0] = k_vld_r;
  assign d_rem[0] = k_num_r;
  assign d_den[0] = k_den_r;
  assign d_quo[0] = 22'd0;
  assign d_fin[0] = k_fin_r;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    rwbh_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .prev_vld (d_vld[g]),
      .prev_rem (d_rem[g]),
      .prev_den (d_den[g]),
      .prev_quo (d_quo[g]),
      .prev_fin (d_fin[g]),
      .next_vld (d_vld[g+1]),
      .next_rem (d_rem[g+1]),
      .next_den (d_den[g+1]),
      .next_quo (d_quo[g+1]),
      .next_fin (d_fin[g+1])
    );
  end

  // output stage: step along the hit edge by the quotient
  fin_ctx_t    fl;
  logic [21:0] mv_c, ex_nxt, ey_nxt;
  logic        o_vld_r;
  logic [21:0] o_x_r, o_y_r;
  logic [3:0]  o_kind_r;

  always_comb begin
    fl     = d_fin[DIV_STEPS];
    mv_c   = move_pt(fl.base, 26'(d_quo[DIV_STEPS]), fl.fwd, fl.lim);
    ex_nxt = fl.mv_x ? mv_c : fl.ex;
    ey_nxt = fl.mv_y ? mv_c : fl.ey;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= d_vld[DIV_STEPS];
    end
    o_x_r    <= ex_nxt;
    o_y_r    <= ey_nxt;
    o_kind_r <= fl.kind;
  end

  assign out_valid    = o_vld_r;
  assign out_end_x    = o_x_r;
  assign out_end_y    = o_y_r;
  assign out_hit_kind = o_kind_r;

  // every transfer in gives exactly one strobe; reset empties the chain; hit codes stay in range
  `RWBH_ASSERT(a_latency, (start && !busy) |-> ##45 out_valid, "result strobe missing")
  `RWBH_ASSERT(a_no_extra, !(start && !busy) |-> ##45 !out_valid, "unexpected result strobe")
  `RWBH_ASSERT_ALL(a_reset_empty, !rst_n |=> (busy && !out_valid), "reset did not empty chain")
  `RWBH_ASSERT(a_kind_range, out_valid |-> (out_hit_kind <= KIND_BR), "hit code out of range")

endmodule

`default_nettype wire

@@ tb/tb_ray_window_border_hit_unit.sv @@
// testbench for ray_window_border_hit_unit: directed and random ray queries
// checked against an in-bench predictor of the border hit; depends on rwbh_pkg
`timescale 1ns / 1ps

class hit_scoreboard;
  logic [21:0] exp_x[$];
  logic [21:0] exp_y[$];
  logic [3:0]  exp_kind[$];
  int          n_bad;
  int          n_checked;

  function new();
    n_bad = 0;
    n_checked = 0;
  endfunction

  function void note_query(logic [21:0] ex, logic [21:0] ey, logic [3:0] k);
    exp_x.push_back(ex);
    exp_y.push_back(ey);
    exp_kind.push_back(k);
  endfunction

  task report(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    n_bad++;
  endtask

  task check_result(logic [21:0] gx, logic [21:0] gy, logic [3:0] gk);
    logic [21:0] ex;
    logic [21:0] ey;
    logic [3:0]  ek;
    if (exp_x.size() == 0) begin
      report($sformatf("unexpected result x=%0d y=%0d kind=%0d", gx, gy, gk));
      return;
    end
    ex = exp_x.pop_front();
    ey = exp_y.pop_front();
    ek = exp_kind.pop_front();
    n_checked++;
    if (gx !== ex) report($sformatf("end_x got %0d want %0d", gx, ex));
    if (gy !== ey) report($sformatf("end_y got %0d want %0d", gy, ey));
    if (gk !== ek) report($sformatf("hit_kind got %0d want %0d", gk, ek));
  endtask

  function int pending();
    return exp_x.size();
  endfunction
endclass

module tb_ray_window_border_hit_unit import rwbh_pkg::*;;

  localparam int LATENCY    = 45;
  localparam int STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [21:0] in_start_x = '0;
  logic [21:0] in_start_y = '0;
  logic [15:0] in_heading = '0;
  logic [23:0] in_travel_distance = '0;
  logic        out_valid;
  logic [21:0] out_end_x;
  logic [21:0] out_end_y;
  logic [3:0]  out_hit_kind;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_WIDTH_IDX;
  logic [14:0] cfg_wdata = '0;

  // predictor's copy of the window registers
  logic [14:0] win_w;
  logic [14:0] win_h;
  logic [9:0]  margin;

  hit_scoreboard sb;
  int          idle_pct;
  int          n_sent;
  int          stall_cnt;
  bit          timed_out;

  // arctangent of 2^-i, 2^32 per turn
  longint      atan_tab[18] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                                21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                                333772, 166886, 83443, 41722, 20861, 10430, 5215};

  always #2 clk = ~clk;

  ray_window_border_hit_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_x(in_start_x), .in_start_y(in_start_y), .in_heading(in_heading),
    .in_travel_distance(in_travel_distance), .out_valid(out_valid),
    .out_end_x(out_end_x), .out_end_y(out_end_y), .out_hit_kind(out_hit_kind),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // floor division by a power of two, for both signs
  function automatic longint fshift(longint v, int k);
    if (v >= 0) return v >>> k;
    return -(((-v) + ((64'sd1 <<< k) - 1)) >>> k);
  endfunction

  // rounded q15 magnitude and sign of one direction component
  function automatic void trig_q15(longint v, output longint mag, output bit neg);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + 16384) >>> 15;
    if (m > 32768) m = 32768;
    mag = m;
    neg = (v < 0) && (m != 0);
  endfunction

  function automatic longint step_pt(longint p, longint q, bit fwd, longint lim);
    if (fwd) return (p + q > lim) ? lim : p + q;
    return (q > p) ? 0 : p - q;
  endfunction

  function automatic longint win_size(logic [14:0] v);
    if (v == 0) return 1;
    if (v > 16384) return 16384;
    return v;
  endfunction

  // expected end point and hit code of one ray
  task automatic predict_hit(input logic [21:0] sx, input logic [21:0] sy,
                             input logic [15:0] hd, input logic [23:0] travel);
    longint xr, yt, x0, y0, d, x, y, z, xs, ys, c, s, cm, sm;
    longint dx, dy, ex, ey, lh, rh, h, v, dh, dv;
    logic [31:0] a32;
    bit cn, sn, right, up, use_x, reached;
    logic [3:0] kind;
    xr = (win_size(win_w) - 1) <<< 8;
    yt = (win_size(win_h) - 1) <<< 8;
    x0 = (sx > xr) ? xr : sx;
    y0 = (sy > yt) ? yt : sy;
    d = travel;
    a32 = {hd, 16'h0};
    x = 652032874;
    y = 0;
    z = a32[29:0];
    for (int i = 0; i < 18; i++) begin
      xs = fshift(x, i);
      ys = fshift(y, i);
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - atan_tab[i];
      end else begin
        x = x + ys; y = y - xs; z = z + atan_tab[i];
      end
    end
    case (a32[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    trig_q15(c, cm, cn);
    trig_q15(s, sm, sn);
    right = !cn;
    up = !sn;
    dx = right ? xr - x0 : x0;
    dy = up ? yt - y0 : y0;
    ex = right ? xr : 0;
    ey = up ? yt : 0;
    lh = dy * cm;
    rh = dx * sm;
    if (lh < rh) begin
      kind = up ? KIND_TOP : KIND_BOTTOM;
      ex = step_pt(x0, (lh + sm / 2) / sm, right, xr);
      use_x = 1'b0;
    end else if (lh > rh) begin
      kind = right ? KIND_RIGHT : KIND_LEFT;
      ey = step_pt(y0, (rh + cm / 2) / cm, up, yt);
      use_x = 1'b1;
    end else begin
      // exact corner: near-axis headings fold onto the edge
      h = hd & 16'h7FFF;
      v = (hd + 16'h4000) & 16'h7FFF;
      dh = (h < 32768 - h) ? h : 32768 - h;
      dv = (v < 32768 - v) ? v : 32768 - v;
      if (dh <= margin) kind = right ? KIND_RIGHT : KIND_LEFT;
      else if (dv <= margin) kind = up ? KIND_TOP : KIND_BOTTOM;
      else kind = up ? (right ? KIND_TR : KIND_TL) : (right ? KIND_BR : KIND_BL);
      use_x = cm >= sm;
    end
    reached = use_x ? ((dx <<< 15) <= d * cm) : ((dy <<< 15) <= d * sm);
    if (!reached) begin
      kind = KIND_NONE;
      ex = step_pt(x0, (d * cm + 16384) >>> 15, right, xr);
      ey = step_pt(y0, (d * sm + 16384) >>> 15, up, yt);
    end
    sb.note_query(ex[21:0], ey[21:0], kind);
  endtask

  // one register write while the pipeline is empty
  task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WIDTH_IDX:  win_w = val;
      CFG_HEIGHT_IDX: win_h = val;
      default:        margin = val[9:0];
    endcase
  endtask

  task automatic set_window(input logic [14:0] w, input logic [14:0] h,
                            input logic [9:0] m);
    write_reg(CFG_WIDTH_IDX, w);
    write_reg(CFG_HEIGHT_IDX, h);
    write_reg(CFG_MARGIN_IDX, {5'd0, m});
  endtask

  // one query transfer, with a random sender gap first
  task automatic send_ray(input logic [21:0] sx, input logic [21:0] sy,
                          input logic [15:0] hd, input logic [23:0] travel);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_start_x <= sx;
    in_start_y <= sy;
    in_heading <= hd;
    in_travel_distance <= travel;
    // busy is seen as it stood before the edge
    @(posedge clk iff !busy);
    predict_hit(sx, sy, hd, travel);
    n_sent++;
  endtask

  // empty the pipeline before touching registers
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0 && !timed_out) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // random ray, mostly inside the window, sometimes anywhere
  task automatic random_ray();
    logic [21:0] sx, sy;
    logic [23:0] travel;
    longint xr, yt;
    xr = (win_size(win_w) - 1) <<< 8;
    yt = (win_size(win_h) - 1) <<< 8;
    if ($urandom_range(9) == 0) begin
      sx = 22'($urandom);
      sy = 22'($urandom);
    end else begin
      sx = 22'($urandom_range(32'(xr)));
      sy = 22'($urandom_range(32'(yt)));
    end
    case ($urandom_range(3))
      0: travel = 24'($urandom);
      1: travel = 24'($urandom_range(4096));
      default: travel = 24'($urandom_range(32'((xr > yt ? xr : yt) * 2 + 256)));
    endcase
    send_ray(sx, sy, 16'($urandom), travel);
  endtask

  // result side: every strobe is a transfer
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_end_x, out_end_y, out_hit_kind);
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired with %0d results outstanding", sb.pending());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    sb = new();
    n_sent = 0;
    stall_cnt = 0;
    timed_out = 1'b0;
    idle_pct = 10;
    win_w = 15'd1920;
    win_h = 15'd1080;
    margin = 10'd1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: axis headings, diagonals, corners, field extremes, reset window
    send_ray(22'd0, 22'd0, 16'h0000, 24'hFFFFFF);
    send_ray(22'd0, 22'd0, 16'h4000, 24'hFFFFFF);
    send_ray(22'd100, 22'd100, 16'h8000, 24'hFFFFFF);
    send_ray(22'd100, 22'd100, 16'hC000, 24'hFFFFFF);
    send_ray(22'd0, 22'd0, 16'h2000, 24'hFFFFFF);
    send_ray(22'h3FFFFF, 22'h3FFFFF, 16'h6000, 24'hFFFFFF);
    send_ray(22'h3FFFFF, 22'h3FFFFF, 16'hA000, 24'hFFFFFF);
    send_ray(22'd0, 22'd0, 16'hE000, 24'hFFFFFF);
    send_ray(22'd1000, 22'd1000, 16'hFFFF, 24'd0);
    send_ray(22'd1000, 22'd1000, 16'h0001, 24'd5000);
    // exact reach: right edge is 1919*256 away from origin
    send_ray(22'd0, 22'd500, 16'h0000, 24'd491264);
    send_ray(22'd0, 22'd500, 16'h0000, 24'd491263);
    drain();

    // square window: diagonal from the centre lands exactly on corners
    set_window(15'd101, 15'd101, 10'd0);
    send_ray(22'd12800, 22'd12800, 16'h2000, 24'hFFFFFF);
    send_ray(22'd12800, 22'd12800, 16'h6000, 24'hFFFFFF);
    send_ray(22'd12800, 22'd12800, 16'hA000, 24'hFFFFFF);
    send_ray(22'd12800, 22'd12800, 16'hE000, 24'hFFFFFF);
    drain();
    // degenerate one-pixel-wide window with clamped height, near-axis corner folding with a wide margin
    set_window(15'd0, 15'h7FFF, 10'd1023);
    send_ray(22'd5, 22'd5, 16'h2000, 24'd100);
    send_ray(22'd0, 22'd0, 16'h0000, 24'd0);
    send_ray(22'd0, 22'd0, 16'h4000, 24'd0);
    send_ray(22'd0, 22'd0, 16'h8000, 24'd0);
    drain();

    // random phases over several window settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_window(15'd1920, 15'd1080, 10'd1);
        1: set_window(15'd16384, 15'd16384, 10'd1023);
        2: set_window(15'd1, 15'd1, 10'd0);
        3: set_window(15'($urandom_range(1, 64)), 15'($urandom_range(1, 64)),
                      10'($urandom_range(1023)));
        4: set_window(15'h7FFF, 15'($urandom_range(1, 16384)), 10'($urandom_range(64)));
        default: set_window(15'($urandom_range(1, 16384)), 15'($urandom_range(1, 16384)),
                            10'($urandom_range(1023)));
      endcase
      idle_pct = (ph < 2) ? 10 : (ph < 4) ? 80 : 0;
      for (int i = 0; i < 80; i++) random_ray();
      drain();
    end

    start <= 1'b0;
    drain();
    $display("sent %0d rays, checked %0d results over directed, corner and random window",
             n_sent, sb.n_checked);
    $display("settings, including degenerate and maximal windows");
    if (sb.n_bad == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      if (sb.pending() != 0) $display("%0d results never arrived", sb.pending());
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ ray_window_border_hit_unit.f @@
+incdir+hw/rtl
hw/rtl/rwbh_pkg.sv
hw/rtl/rwbh_cordic_cell.sv
hw/rtl/rwbh_div_cell.sv
hw/rtl/ray_window_border_hit_unit.sv
tb/tb_ray_window_border_hit_unit.sv
